// ===== rtl/core/comment_stripper_core_assert.svh =====
// assertion macros for the comment stripper core
// no dependencies; included by files that carry concurrent checks
`ifndef COMMENT_STRIPPER_CORE_ASSERT_SVH
`define COMMENT_STRIPPER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CSTR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define CSTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define CSTR_ASSERT_SAME(label, clk, rst, ante, cons)
`define CSTR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/cstr_pkg.sv =====
// shared types and constants for the comment stripper core
// no dependencies; used by every module of the block
package cstr_pkg;

   localparam int BYTE_W    = 8;
   localparam int DELIM_W   = 64;
   localparam int LEN_W     = 4;
   localparam int CNT_W     = 3;
   localparam int CSR_IDX_W = 2;
   localparam int MAX_DELIM = 8;

   localparam logic [BYTE_W-1:0] SQUOTE  = 8'h27;
   localparam logic [BYTE_W-1:0] DQUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] BSLASH  = 8'h5C;
   localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

   localparam logic [DELIM_W-1:0] BEGIN_DELIM_RST = 64'h2A2F;
   localparam logic [LEN_W-1:0]   BEGIN_LEN_RST   = 4'd2;
   localparam logic [DELIM_W-1:0] END_DELIM_RST   = 64'h2F2A;
   localparam logic [LEN_W-1:0]   END_LEN_RST     = 4'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BEGIN_DELIM = 2'd0,
      CSR_BEGIN_LEN   = 2'd1,
      CSR_END_DELIM   = 2'd2,
      CSR_END_LEN     = 2'd3
   } cstr_csr_idx_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              text_start;
   } cstr_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
   } cstr_rsp_type;

   typedef struct packed {
      logic [DELIM_W-1:0] begin_delim;
      logic [LEN_W-1:0]   begin_len;
      logic [DELIM_W-1:0] end_delim;
      logic [LEN_W-1:0]   end_len;
   } cstr_cfg_type;

   // work for the back end: release flush_cnt begin bytes, then maybe one byte
   typedef struct packed {
      logic [CNT_W-1:0]  flush_cnt;
      logic              tail_valid;
      logic [BYTE_W-1:0] tail_byte;
   } cstr_desc_type;

   typedef struct packed {
      logic nonempty;
      logic full;
   } cstr_qstat_type;

   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] r;
      if (v == '0) begin
         r = LEN_W'(1);
      end else if (v > LEN_W'(MAX_DELIM)) begin
         r = LEN_W'(MAX_DELIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] delim_byte(input logic [DELIM_W-1:0] d,
                                                    input logic [CNT_W-1:0]   i);
      return d[i*BYTE_W +: BYTE_W];
   endfunction

endpackage

// ===== rtl/core/comment_stripper_core.sv =====
// top level of the comment stripper: control registers, front end, work queue, back end
// depends on cstr_pkg, cstr_front, cstr_queue, cstr_back and the assertion macro header
`include "comment_stripper_core_assert.svh"

// Removes delimited comments from a byte stream, passing quoted literals through.
// The front end takes one byte per cycle while req_stall is low and classifies it
// against the current scan mode; each byte that yields output leaves a work item in
// a QUEUE_DEPTH deep queue. The back end turns each work item into results at one
// per cycle while rsp_stall is low: a byte that ends a failed begin match of k
// bytes gives up to k + 1 results, any other byte at most one. The sustained rate
// is one byte per cycle; req_stall rises only when the queue is full, which happens
// when partial-match releases outrun the result side or rsp_stall holds results
// back. A byte's work item goes into a queue slot and its results into the output
// register. Registers must be written through the csr port only while no item is in
// flight; the block itself does not enforce this, and csr_ready is always high.
module comment_stripper_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cstr_pkg::cstr_req_type            req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cstr_pkg::cstr_rsp_type            rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cstr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cstr_pkg::DELIM_W-1:0]      csr_data
);
   import cstr_pkg::*;

   cstr_cfg_type   cfg_ff;
   cstr_desc_type  push_desc, head_desc;
   cstr_qstat_type qstat;
   logic           accept, push, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.begin_delim <= BEGIN_DELIM_RST;
         cfg_ff.begin_len   <= BEGIN_LEN_RST;
         cfg_ff.end_delim   <= END_DELIM_RST;
         cfg_ff.end_len     <= END_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BEGIN_DELIM: cfg_ff.begin_delim <= csr_data;
            CSR_BEGIN_LEN:   cfg_ff.begin_len   <= csr_data[LEN_W-1:0];
            CSR_END_DELIM:   cfg_ff.end_delim   <= csr_data;
            CSR_END_LEN:     cfg_ff.end_len     <= csr_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;

   cstr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cfg    (cfg_ff),
      .push   (push),
      .desc   (push_desc)
   );

   cstr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .stat      (qstat)
   );

   cstr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_desc   (head_desc),
      .stat        (qstat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // queue never written while full
   `CSTR_ASSERT_SAME(a_no_overflow, clock, reset, push, !qstat.full)
   // back end only retires work that exists
   `CSTR_ASSERT_SAME(a_no_underflow, clock, reset, pop, qstat.nonempty)
   // with nothing queued, a freed output register stays empty
   `CSTR_ASSERT_NEXT(a_no_invented_rsp, clock, reset,
                     (!rsp_valid || !rsp_stall) && !qstat.nonempty, !rsp_valid)

endmodule

// ===== rtl/core/cstr_front.sv =====
// front end: accepts source bytes, tracks the scan mode and emits work items
// depends on cstr_pkg
module cstr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  cstr_pkg::cstr_req_type req,
   input  cstr_pkg::cstr_cfg_type cfg,
   output logic                  push,
   output cstr_pkg::cstr_desc_type desc
);
   import cstr_pkg::*;

   typedef enum logic [2:0] {
      SM_NORMAL   = 3'd0,
      SM_SINGLE   = 3'd1,
      SM_SING_ESC = 3'd2,
      SM_DOUBLE   = 3'd3,
      SM_DBL_ESC  = 3'd4,
      SM_COMMENT  = 3'd5,
      SM_BEGIN    = 3'd6,
      SM_END      = 3'd7
   } mode_type;

   mode_type          mode_ff, mode_in, mode_cur;
   logic [CNT_W-1:0]  match_ff, match_in, cnt_cur;
   logic [LEN_W-1:0]  blen, elen;
   logic [BYTE_W-1:0] c;
   logic              do_normal, do_comment;

   assign c    = req.data_byte;
   assign blen = eff_len(cfg.begin_len);
   assign elen = eff_len(cfg.end_len);

   always_comb begin
      mode_cur        = req.text_start ? SM_NORMAL : mode_ff;
      cnt_cur         = req.text_start ? '0 : match_ff;
      mode_in         = mode_cur;
      match_in        = cnt_cur;
      do_normal       = 1'b0;
      do_comment      = 1'b0;
      desc.flush_cnt  = '0;
      desc.tail_valid = 1'b0;
      desc.tail_byte  = c;

      case (mode_cur)
         SM_NORMAL: begin
            do_normal = 1'b1;
         end
         SM_SINGLE: begin
            desc.tail_valid = 1'b1;
            if (c == SQUOTE) begin
               mode_in = SM_NORMAL;
            end else if (c == BSLASH) begin
               mode_in = SM_SING_ESC;
            end
         end
         SM_SING_ESC: begin
            desc.tail_valid = 1'b1;
            mode_in         = SM_SINGLE;
         end
         SM_DOUBLE: begin
            desc.tail_valid = 1'b1;
            if (c == DQUOTE) begin
               mode_in = SM_NORMAL;
            end else if (c == BSLASH) begin
               mode_in = SM_DBL_ESC;
            end
         end
         SM_DBL_ESC: begin
            desc.tail_valid = 1'b1;
            mode_in         = SM_DOUBLE;
         end
         SM_COMMENT: begin
            do_comment = 1'b1;
         end
         SM_BEGIN: begin
            if ({1'b0, cnt_cur} < blen && c == delim_byte(cfg.begin_delim, cnt_cur)) begin
               if ({1'b0, cnt_cur} + LEN_W'(1) == blen) begin
                  mode_in  = SM_COMMENT;
                  match_in = '0;
               end else begin
                  match_in = cnt_cur + CNT_W'(1);
               end
            end else begin
               // release the partial match, then treat the byte as fresh text
               desc.flush_cnt = cnt_cur;
               mode_in        = SM_NORMAL;
               match_in       = '0;
               do_normal      = 1'b1;
            end
         end
         SM_END: begin
            if ({1'b0, cnt_cur} < elen && c == delim_byte(cfg.end_delim, cnt_cur)) begin
               if ({1'b0, cnt_cur} + LEN_W'(1) == elen) begin
                  mode_in  = SM_NORMAL;
                  match_in = '0;
               end else begin
                  match_in = cnt_cur + CNT_W'(1);
               end
            end else begin
               mode_in    = SM_COMMENT;
               match_in   = '0;
               do_comment = 1'b1;
            end
         end
         default: begin
            mode_in = SM_NORMAL;
         end
      endcase

      if (do_normal) begin
         if (c == SQUOTE) begin
            desc.tail_valid = 1'b1;
            mode_in         = SM_SINGLE;
         end else if (c == DQUOTE) begin
            desc.tail_valid = 1'b1;
            mode_in         = SM_DOUBLE;
         end else if (c == delim_byte(cfg.begin_delim, '0)) begin
            if (blen == LEN_W'(1)) begin
               mode_in = SM_COMMENT;
            end else begin
               mode_in  = SM_BEGIN;
               match_in = CNT_W'(1);
            end
         end else begin
            desc.tail_valid = 1'b1;
         end
      end

      if (do_comment && c == delim_byte(cfg.end_delim, '0)) begin
         if (elen == LEN_W'(1)) begin
            // a newline terminator stays in the text
            desc.tail_valid = (c == NEWLINE);
            mode_in         = SM_NORMAL;
            match_in        = '0;
         end else begin
            mode_in  = SM_END;
            match_in = CNT_W'(1);
         end
      end
   end

   assign push = accept && (desc.flush_cnt != '0 || desc.tail_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= SM_NORMAL;
         match_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         match_ff <= match_in;
      end
   end

endmodule

// ===== rtl/core/cstr_queue.sv =====
// short work queue between front and back end
// depends on cstr_pkg
module cstr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cstr_pkg::cstr_desc_type push_desc,
   input  logic                    pop,
   output cstr_pkg::cstr_desc_type head_desc,
   output cstr_pkg::cstr_qstat_type stat
);
   import cstr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cstr_desc_type  slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   assign wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
   assign rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign head_desc     = slot_ff[rd_ptr_ff];
   assign stat.nonempty = (count_ff != '0);
   assign stat.full     = (count_ff == CW'(DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/cstr_back.sv =====
// back end: expands work items into result bytes, one per cycle while rsp_stall is low, into an output register
// depends on cstr_pkg
module cstr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  cstr_pkg::cstr_cfg_type   cfg,
   input  cstr_pkg::cstr_desc_type  head_desc,
   input  cstr_pkg::cstr_qstat_type stat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cstr_pkg::cstr_rsp_type   rsp_payload
);
   import cstr_pkg::*;

   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cstr_rsp_type     rsp_ff, rsp_in;
   logic             load, in_flush, last;

   // output register frees up when empty or being taken this cycle
   assign load     = !rsp_valid_ff || !rsp_stall;
   assign in_flush = pos_ff < head_desc.flush_cnt;
   assign last     = in_flush ? ({1'b0, pos_ff} + (CNT_W+1)'(1) == {1'b0, head_desc.flush_cnt}
                                 && !head_desc.tail_valid)
                              : 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pos_in       = pos_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = stat.nonempty;
         if (stat.nonempty) begin
            rsp_in.out_byte = in_flush ? delim_byte(cfg.begin_delim, pos_ff)
                                       : head_desc.tail_byte;
            rsp_in.run_last = last;
            if (last) begin
               pop    = 1'b1;
               pos_in = '0;
            end else begin
               pos_in = pos_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== bench/tb_comment_stripper_core.sv =====
// testbench for comment_stripper_core: byte stream in, stripped text out, csr writes between phases
// depends on cstr_pkg and the comment_stripper_core rtl; self-checking against an in-bench predictor
module tb_comment_stripper_core;
   timeunit 1ns;
   timeprecision 1ps;
   import cstr_pkg::*;

   typedef enum logic [2:0] {
      ST_NORMAL, ST_SQUOTE, ST_SQUOTE_ESC, ST_DQUOTE,
      ST_DQUOTE_ESC, ST_COMMENT, ST_BEGIN_MATCH, ST_END_MATCH
   } scan_state_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC, STALL_LONG} stall_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   cstr_req_type         req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   cstr_rsp_type         rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DELIM_W-1:0]   csr_data = '0;

   // predictor copy of the registers and scan state
   logic [DELIM_W-1:0] cfg_begin_delim = BEGIN_DELIM_RST;
   logic [LEN_W-1:0]   cfg_begin_len   = BEGIN_LEN_RST;
   logic [DELIM_W-1:0] cfg_end_delim   = END_DELIM_RST;
   logic [LEN_W-1:0]   cfg_end_len     = END_LEN_RST;
   scan_state_type     scan_st = ST_NORMAL;
   int                 match_cnt = 0;

   logic [BYTE_W-1:0] stripped_bytes[$];
   cstr_rsp_type      expected_out[$];
   cstr_rsp_type      rsp_want;

   int             burst_left = 0;
   int             bytes_sent = 0;
   int             mismatch_count = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   comment_stripper_core u_top (.*);

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int clamp_len(input logic [LEN_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DELIM) return MAX_DELIM;
      return int'(v);
   endfunction

   function automatic logic [BYTE_W-1:0] delim_at(input logic [DELIM_W-1:0] d, input int i);
      return d[(i % 8) * 8 +: 8];
   endfunction

   function automatic void keep_byte(input logic [BYTE_W-1:0] b);
      stripped_bytes = {stripped_bytes, b};
   endfunction

   function automatic void scan_normal(input logic [BYTE_W-1:0] c);
      // a quote opens a literal even when it is also the first begin byte
      if (c == SQUOTE) begin
         keep_byte(c);
         scan_st = ST_SQUOTE;
      end else if (c == DQUOTE) begin
         keep_byte(c);
         scan_st = ST_DQUOTE;
      end else if (c == delim_at(cfg_begin_delim, 0)) begin
         if (clamp_len(cfg_begin_len) == 1) begin
            scan_st = ST_COMMENT;
         end else begin
            scan_st = ST_BEGIN_MATCH;
            match_cnt = 1;
         end
      end else begin
         keep_byte(c);
      end
   endfunction

   function automatic void scan_comment(input logic [BYTE_W-1:0] c);
      if (c == delim_at(cfg_end_delim, 0)) begin
         if (clamp_len(cfg_end_len) == 1) begin
            // a lone newline terminator stays in the text
            if (c == NEWLINE) keep_byte(c);
            scan_st = ST_NORMAL;
            match_cnt = 0;
         end else begin
            scan_st = ST_END_MATCH;
            match_cnt = 1;
         end
      end
   endfunction

   function automatic void strip_byte(input cstr_req_type item);
      logic [BYTE_W-1:0] c;
      int                len;
      cstr_rsp_type      res;
      c = item.data_byte;
      stripped_bytes.delete();
      if (item.text_start) begin
         scan_st = ST_NORMAL;
         match_cnt = 0;
      end
      case (scan_st)
         ST_NORMAL: scan_normal(c);
         ST_SQUOTE: begin
            if (c == SQUOTE) scan_st = ST_NORMAL;
            else if (c == BSLASH) scan_st = ST_SQUOTE_ESC;
            keep_byte(c);
         end
         ST_SQUOTE_ESC: begin
            keep_byte(c);
            scan_st = ST_SQUOTE;
         end
         ST_DQUOTE: begin
            if (c == DQUOTE) scan_st = ST_NORMAL;
            else if (c == BSLASH) scan_st = ST_DQUOTE_ESC;
            keep_byte(c);
         end
         ST_DQUOTE_ESC: begin
            keep_byte(c);
            scan_st = ST_DQUOTE;
         end
         ST_COMMENT: scan_comment(c);
         ST_BEGIN_MATCH: begin
            len = clamp_len(cfg_begin_len);
            if (match_cnt < len && c == delim_at(cfg_begin_delim, match_cnt)) begin
               if (match_cnt + 1 == len) begin
                  scan_st = ST_COMMENT;
                  match_cnt = 0;
               end else begin
                  match_cnt++;
               end
            end else begin
               // give back the held begin bytes, then the byte is scanned as fresh text
               for (int i = 0; i < match_cnt; i++)
                  keep_byte(delim_at(cfg_begin_delim, i));
               scan_st = ST_NORMAL;
               match_cnt = 0;
               scan_normal(c);
            end
         end
         default: begin
            len = clamp_len(cfg_end_len);
            if (match_cnt < len && c == delim_at(cfg_end_delim, match_cnt)) begin
               if (match_cnt + 1 == len) begin
                  scan_st = ST_NORMAL;
                  match_cnt = 0;
               end else begin
                  match_cnt++;
               end
            end else begin
               scan_st = ST_COMMENT;
               match_cnt = 0;
               scan_comment(c);
            end
         end
      endcase
      foreach (stripped_bytes[i]) begin
         res.out_byte = stripped_bytes[i];
         res.run_last = (i == stripped_bytes.size() - 1);
         expected_out = {expected_out, res};
      end
   endfunction

   // ---------------------------------------------------------------- result side

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 4));
            stall_left = $urandom_range(16, 96);
         end
         stall_left--;
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: rsp_stall <= (stall_left % 3 == 0);
            default:        rsp_stall <= (stall_left % 16 < 10);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result with nothing pending: byte %02h last %0b",
                        $realtime, rsp_payload.out_byte, rsp_payload.run_last);
         end else begin
            rsp_want = expected_out.pop_front();
            if (rsp_payload.out_byte !== rsp_want.out_byte ||
                rsp_payload.run_last !== rsp_want.run_last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: byte %02h last %0b, expected byte %02h last %0b",
                           $realtime, rsp_payload.out_byte, rsp_payload.run_last,
                           rsp_want.out_byte, rsp_want.run_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
      cstr_req_type item;
      int           gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      item.data_byte = b;
      item.text_start = start;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      strip_byte(item);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], i == 0);
   endtask

   task automatic send_delim(input logic [DELIM_W-1:0] d, input int n);
      for (int i = 0; i < n; i++)
         send_byte(delim_at(d, i), 1'b0);
   endtask

   // drain: nothing pending, then enough cycles for byte that yields no output
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [DELIM_W-1:0] len_word(input logic [LEN_W-1:0] l);
      logic [DELIM_W-1:0] w;
      w = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
      w[LEN_W-1:0] = l;
      return w;
   endfunction

   task automatic write_regs(input logic [DELIM_W-1:0] bd, input logic [LEN_W-1:0] bl,
                             input logic [DELIM_W-1:0] ed, input logic [LEN_W-1:0] el);
      logic [DELIM_W-1:0] vals [4];
      cstr_csr_idx_type   idx;
      settle();
      vals[CSR_BEGIN_DELIM] = bd;
      vals[CSR_BEGIN_LEN]   = len_word(bl);
      vals[CSR_END_DELIM]   = ed;
      vals[CSR_END_LEN]     = len_word(el);
      for (int k = 0; k < 4; k++) begin
         idx = cstr_csr_idx_type'(k);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= vals[idx];
         do @(posedge clock); while (!csr_ready);
         case (idx)
            CSR_BEGIN_DELIM: cfg_begin_delim = vals[idx];
            CSR_BEGIN_LEN:   cfg_begin_len = vals[idx][LEN_W-1:0];
            CSR_END_DELIM:   cfg_end_delim = vals[idx];
            default:         cfg_end_len = vals[idx][LEN_W-1:0];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [BYTE_W-1:0] text_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return 8'($urandom_range(8'h61, 8'h7A));
      if (r == 4) return delim_at(cfg_begin_delim, 0);
      if (r == 5) return delim_at(cfg_end_delim, $urandom_range(0, 7));
      if (r == 6) return NEWLINE;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic put_token();
      int                kind;
      int                n;
      int                blen;
      int                elen;
      logic [BYTE_W-1:0] q;
      kind = $urandom_range(0, 99);
      blen = clamp_len(cfg_begin_len);
      elen = clamp_len(cfg_end_len);
      n = $urandom_range(0, 6);
      if (kind < 25) begin
         repeat (n + 1) send_byte(text_byte(), 1'b0);
      end else if (kind < 50) begin
         send_delim(cfg_begin_delim, blen);
         repeat (n) send_byte(text_byte(), 1'b0);
         send_delim(cfg_end_delim, elen);
      end else if (kind < 65) begin
         q = ($urandom_range(0, 1) == 0) ? SQUOTE : DQUOTE;
         send_byte(q, 1'b0);
         repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
               send_byte(BSLASH, 1'b0);
               send_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
               send_byte(text_byte(), 1'b0);
            end
         end
         send_byte(q, 1'b0);
      end else if (kind < 78) begin
         // begin prefix that breaks off
         send_delim(cfg_begin_delim, (blen > 1) ? $urandom_range(1, blen - 1) : 1);
         send_byte(text_byte(), 1'b0);
      end else if (kind < 88) begin
         // comment whose first end attempt may break off
         send_delim(cfg_begin_delim, blen);
         send_delim(cfg_end_delim, $urandom_range(1, elen));
         send_byte(text_byte(), 1'b0);
         send_delim(cfg_end_delim, elen);
      end else if (kind < 95) begin
         repeat (n / 2 + 1) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         send_byte(text_byte(), 1'b1);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_delims();
      send_text("a/*x*/b");
      send_text("\"/\"");
      send_text("'\\''");
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      // new text while a begin match is pending drops the held byte
      send_text("/");
      send_byte("z", 1'b1);
   endtask

   task automatic test_special_cases();
      write_regs(64'h23, 4'd0, {56'h0, NEWLINE}, 4'd1);
      send_text("#a\n");
      write_regs({{56{1'b1}}, SQUOTE}, 4'd15, '0, 4'd8);
      send_text("'x'");
      write_regs(64'h2A2A2F, 4'd3, END_DELIM_RST, END_LEN_RST);
      send_text("/*");
      // shrink the begin length under a two-byte partial match
      write_regs(64'h2A2A2F, 4'd2, END_DELIM_RST, END_LEN_RST);
      send_byte("k", 1'b0);
   endtask

   task automatic test_random_text();
      logic [DELIM_W-1:0] bd;
      logic [DELIM_W-1:0] ed;
      int                 goal;
      for (int p = 0; p < 7; p++) begin
         bd = {$urandom, $urandom};
         ed = {$urandom, $urandom};
         case (p)
            0: write_regs(BEGIN_DELIM_RST, BEGIN_LEN_RST, END_DELIM_RST, END_LEN_RST);
            1: write_regs(64'h23, 4'd1, {56'h0, NEWLINE}, 4'd1);
            2: write_regs('1, 4'd8, '0, 4'd8);
            3: write_regs(bd, 4'd0, ed, 4'd15);
            4: begin
               bd[7:0] = DQUOTE;
               write_regs(bd, 4'd2, ed, 4'd3);
            end
            default: write_regs(bd, 4'($urandom_range(0, 15)), ed, 4'($urandom_range(0, 15)));
         endcase
         goal = bytes_sent + 22;
         send_byte(text_byte(), $urandom_range(0, 3) != 0);
         while (bytes_sent < goal) put_token();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_delims();
      test_special_cases();
      test_random_text();
      settle();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #1ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
